// ===== rtl/scsc_pkg.sv =====
// Package with the codes, types and sense data decode function of the SCSI sense classifier.
package scsc_pkg;

  localparam int unsigned StoreDepth = 13;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);

  localparam logic [4:0] OutGood         = 5'd0;
  localparam logic [4:0] OutBadKnown     = 5'd1;
  localparam logic [4:0] OutRecKnown     = 5'd3;
  localparam logic [4:0] OutHardware     = 5'd5;
  localparam logic [4:0] OutIllegalReq   = 5'd6;
  localparam logic [4:0] OutOtherCode    = 5'd7;
  localparam logic [4:0] OutQuiet        = 5'd8;
  localparam logic [4:0] OutSeek         = 5'd9;
  localparam logic [4:0] OutIllegalCmd   = 5'd10;
  localparam logic [4:0] OutIllegalAddr  = 5'd11;
  localparam logic [4:0] OutBadArg       = 5'd12;
  localparam logic [4:0] OutCartChanged  = 5'd13;
  localparam logic [4:0] OutInvalidLun   = 5'd14;
  localparam logic [4:0] OutUnformatted  = 5'd15;
  localparam logic [4:0] OutNoError      = 5'd16;
  localparam logic [4:0] OutUnknownLeg   = 5'd17;
  localparam logic [4:0] OutBadSense     = 5'd18;

  localparam logic [3:0] KeyRecovered = 4'd1;
  localparam logic [3:0] KeyMedium    = 4'd3;
  localparam logic [3:0] KeyHardware  = 4'd4;
  localparam logic [3:0] KeyIllegal   = 4'd5;

  localparam logic [6:0] LegNone      = 7'h00;
  localparam logic [6:0] LegBad01     = 7'h01;
  localparam logic [6:0] LegSeek02    = 7'h02;
  localparam logic [6:0] LegBad03     = 7'h03;
  localparam logic [6:0] LegBad11     = 7'h11;
  localparam logic [6:0] LegBad12     = 7'h12;
  localparam logic [6:0] LegBad14     = 7'h14;
  localparam logic [6:0] LegSeek15    = 7'h15;
  localparam logic [6:0] LegRecovered = 7'h18;
  localparam logic [6:0] LegBad19     = 7'h19;
  localparam logic [6:0] LegUnformat  = 7'h1C;
  localparam logic [6:0] LegIllCmd    = 7'h20;
  localparam logic [6:0] LegIllAddr   = 7'h21;
  localparam logic [6:0] LegBadArg    = 7'h24;
  localparam logic [6:0] LegBadLun    = 7'h25;
  localparam logic [6:0] LegCartChg   = 7'h28;

  typedef logic [7:0] store_t [StoreDepth];

  typedef struct packed {
    logic [4:0]  outcome;
    logic        stop;
    logic        ext;
    logic        known;
    logic [31:0] block;
    logic [6:0]  key;
    logic        code_known;
    logic [7:0]  code;
    logic        bump;
  } class_t;

  function automatic logic [4:0] pair_outcome(input logic [4:0] base, input logic known);
    return known ? base : base + 5'd1;
  endfunction

  function automatic class_t classify(input store_t st, input logic [7:0] len);
    class_t r;
    logic [31:0] blk;
    logic [3:0] xkey;
    r = '0;
    if (len >= 8'd3 && (st[0] & 8'h7E) == 8'h70) begin
      r.ext = 1'b1;
      if (len >= 8'd7 && st[0][7]) begin
        blk = {st[3], st[4], st[5], st[6]};
        r.known = (blk != 32'hFFFF_FFFF);
        r.block = blk;
      end
      xkey = st[2][3:0];
      r.key = {3'b000, xkey};
      if (len >= 8'd13) begin
        r.code_known = 1'b1;
        r.code = st[12];
      end
      priority if (xkey == KeyMedium) begin
        r.outcome = pair_outcome(OutBadKnown, r.known);
        r.bump = 1'b1;
      end else if (xkey == KeyHardware) begin
        r.outcome = OutHardware;
      end else if (xkey == KeyRecovered) begin
        r.outcome = pair_outcome(OutRecKnown, r.known);
        r.bump = 1'b1;
      end else if (xkey == KeyIllegal) begin
        r.outcome = OutIllegalReq;
      end else if (r.code_known && r.code != 8'd0) begin
        r.outcome = OutOtherCode;
      end else begin
        r.outcome = OutQuiet;
      end
    end else if (len == 8'd4) begin
      if (st[0][7]) begin
        r.known = 1'b1;
        r.block = {11'd0, st[1][4:0], st[2], st[3]};
      end
      r.key = st[0][6:0];
      unique case (r.key)
        LegSeek15, LegSeek02: r.outcome = OutSeek;
        LegBad01, LegBad03, LegBad11, LegBad12, LegBad14, LegBad19: begin
          r.outcome = pair_outcome(OutBadKnown, r.known);
          r.bump = 1'b1;
        end
        LegRecovered: begin
          r.outcome = pair_outcome(OutRecKnown, r.known);
          r.bump = 1'b1;
        end
        LegIllCmd:   r.outcome = OutIllegalCmd;
        LegIllAddr:  r.outcome = OutIllegalAddr;
        LegBadArg:   r.outcome = OutBadArg;
        LegCartChg:  r.outcome = OutCartChanged;
        LegBadLun:   r.outcome = OutInvalidLun;
        LegUnformat: r.outcome = OutUnformatted;
        LegNone:     r.outcome = OutNoError;
        default:     r.outcome = OutUnknownLeg;
      endcase
    end else begin
      r.outcome = OutBadSense;
      r.stop = 1'b1;
    end
    if (!r.known) begin
      r.block = '0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/scsi_sense_classifier.sv =====
// Top level of the SCSI sense classifier: byte collection, decode stage and result register.
// The block takes one request per cycle while in_ready_o is high, both status and sense byte requests. A
// status request with good status, a bad status with no sense bytes, and the last sense byte of a bad
// status each give one result; all other requests give none. Taking the request stores the byte and
// latches the sense length into the decode stage, which decodes the collected sense data into the
// result register once that is free; both registers lie between a request and its result. The rate
// is bounded only by the result register: while a result waits to be taken, one more request that
// gives a result can be held before the input stalls.
module scsi_sense_classifier
  import scsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  status_byte_i,
  input  logic [7:0]  sense_length_i,
  input  logic [7:0]  sense_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  outcome_o,
  output logic        stop_request_o,
  output logic        is_extended_o,
  output logic        block_known_o,
  output logic [31:0] block_address_o,
  output logic [31:0] resume_block_o,
  output logic [6:0]  sense_key_o,
  output logic        code_known_o,
  output logic [7:0]  additional_code_o,
  output logic [31:0] bad_block_total_o
);

  store_t      store_q;
  logic [7:0]  expected_q, expected_d;
  logic [7:0]  seen_q, seen_d;
  logic        collecting_q, collecting_d;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_good_q, s1_good_d;
  logic [7:0]  s1_len_q, s1_len_d;
  logic        s1_load;
  logic        s1_adv;
  logic        in_acc;
  logic        store_we;
  logic        out_valid_q;
  logic [31:0] bad_block_q, bad_block_d;
  class_t      cls;
  logic [7:0]  seen_inc;

  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign seen_inc   = seen_q + 8'd1;
  assign store_we   = in_acc && req_type_i && collecting_q && (seen_q < 8'(StoreDepth));

  always_comb begin
    collecting_d = collecting_q;
    seen_d       = seen_q;
    expected_d   = expected_q;
    s1_load      = 1'b0;
    s1_good_d    = s1_good_q;
    s1_len_d     = s1_len_q;
    if (in_acc) begin
      if (!req_type_i) begin
        seen_d       = '0;
        expected_d   = sense_length_i;
        collecting_d = (status_byte_i != 8'd0) && (sense_length_i != 8'd0);
        s1_load      = !collecting_d;
        s1_good_d    = (status_byte_i == 8'd0);
        s1_len_d     = sense_length_i;
      end else if (collecting_q) begin
        seen_d = seen_inc;
        if (seen_inc == expected_q) begin
          collecting_d = 1'b0;
          s1_load      = 1'b1;
          s1_good_d    = 1'b0;
          s1_len_d     = expected_q;
        end
      end
    end
    s1_valid_d = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      seen_q       <= '0;
      expected_q   <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      seen_q       <= seen_d;
      expected_q   <= expected_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[seen_q[StoreIdxW-1:0]] <= sense_byte_i;
    end
    if (s1_load) begin
      s1_good_q <= s1_good_d;
      s1_len_q  <= s1_len_d;
    end
  end

  assign cls = classify(store_q, s1_len_q);

  always_comb begin
    bad_block_d = bad_block_q;
    if (s1_adv && !s1_good_q && cls.bump && bad_block_q != 32'hFFFF_FFFF) begin
      bad_block_d = bad_block_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bad_block_q <= '0;
    end else begin
      bad_block_q <= bad_block_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      bad_block_total_o <= bad_block_d;
      if (s1_good_q) begin
        outcome_o         <= OutGood;
        stop_request_o    <= 1'b0;
        is_extended_o     <= 1'b0;
        block_known_o     <= 1'b0;
        block_address_o   <= '0;
        resume_block_o    <= '0;
        sense_key_o       <= '0;
        code_known_o      <= 1'b0;
        additional_code_o <= '0;
      end else begin
        outcome_o         <= cls.outcome;
        stop_request_o    <= cls.stop;
        is_extended_o     <= cls.ext;
        block_known_o     <= cls.known;
        block_address_o   <= cls.block;
        resume_block_o    <= cls.known ? cls.block + 32'd1 : 32'd0;
        sense_key_o       <= cls.key;
        code_known_o      <= cls.code_known;
        additional_code_o <= cls.code;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_stop_only_bad_sense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stop_request_o == (outcome_o == OutBadSense)))
    else $error("stop request without bad sense outcome");

  a_counter_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (bad_block_q >= $past(bad_block_q)))
    else $error("bad block counter went down");

  a_collect_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q |-> (seen_q < expected_q))
    else $error("sense byte count passed the expected length");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_len_q) && $stable(s1_good_q)))
    else $error("decode stage changed while stalled");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the SCSI sense classifier with its own sense data decoder.
module tb_top;
  import scsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int ReportLimit = 10;
  localparam logic [4:0] OutBadUnknown = OutBadKnown + 5'd1;
  localparam logic [4:0] OutRecUnknown = OutRecKnown + 5'd1;
  localparam logic [6:0] LegUnknown = 7'h7F;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [4:0]  outcome;
    logic        stop;
    logic        ext;
    logic        known;
    logic [31:0] block;
    logic [31:0] resume;
    logic [6:0]  key;
    logic        code_known;
    logic [7:0]  code;
    logic [31:0] total;
  } sense_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  status_byte_i;
  logic [7:0]  sense_length_i;
  logic [7:0]  sense_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  outcome_o;
  logic        stop_request_o;
  logic        is_extended_o;
  logic        block_known_o;
  logic [31:0] block_address_o;
  logic [31:0] resume_block_o;
  logic [6:0]  sense_key_o;
  logic        code_known_o;
  logic [7:0]  additional_code_o;
  logic [31:0] bad_block_total_o;

  logic [7:0]  sense_mem [StoreDepth];
  logic [7:0]  sense_len;
  logic [7:0]  seen_cnt;
  logic        gathering;
  logic [31:0] bad_total;

  sense_result_t pending_results[$];
  sense_result_t want;
  int fail_count;
  int useful_items;
  int cycle_count;
  int in_gap_pct;
  int out_stall_pct;
  int stall_left;

  scsi_sense_classifier u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .status_byte_i     (status_byte_i),
    .sense_length_i    (sense_length_i),
    .sense_byte_i      (sense_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .outcome_o         (outcome_o),
    .stop_request_o    (stop_request_o),
    .is_extended_o     (is_extended_o),
    .block_known_o     (block_known_o),
    .block_address_o   (block_address_o),
    .resume_block_o    (resume_block_o),
    .sense_key_o       (sense_key_o),
    .code_known_o      (code_known_o),
    .additional_code_o (additional_code_o),
    .bad_block_total_o (bad_block_total_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 8);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [6:0] legacy_code(input int idx);
    case (idx)
      0:       return LegNone;
      1:       return LegBad01;
      2:       return LegSeek02;
      3:       return LegBad03;
      4:       return LegBad11;
      5:       return LegBad12;
      6:       return LegBad14;
      7:       return LegSeek15;
      8:       return LegRecovered;
      9:       return LegBad19;
      10:      return LegUnformat;
      11:      return LegIllCmd;
      12:      return LegIllAddr;
      13:      return LegBadArg;
      14:      return LegBadLun;
      15:      return LegCartChg;
      default: return LegUnknown;
    endcase
  endfunction

  // Decodes the collected sense bytes and updates the bad block count.
  function automatic sense_result_t decode_sense();
    sense_result_t r;
    logic [31:0] blk;
    logic bump;
    r = '0;
    bump = 1'b0;
    if (sense_len >= 8'd3 && (sense_mem[0] & 8'h7E) == 8'h70) begin
      r.ext = 1'b1;
      if (sense_len >= 8'd7 && sense_mem[0][7]) begin
        blk = {sense_mem[3], sense_mem[4], sense_mem[5], sense_mem[6]};
        r.known = (blk != 32'hFFFF_FFFF);
        r.block = blk;
      end
      r.key = {3'b000, sense_mem[2][3:0]};
      if (sense_len >= 8'd13) begin
        r.code_known = 1'b1;
        r.code = sense_mem[12];
      end
      case (sense_mem[2][3:0])
        KeyMedium: begin
          r.outcome = r.known ? OutBadKnown : OutBadUnknown;
          bump = 1'b1;
        end
        KeyHardware: r.outcome = OutHardware;
        KeyRecovered: begin
          r.outcome = r.known ? OutRecKnown : OutRecUnknown;
          bump = 1'b1;
        end
        KeyIllegal: r.outcome = OutIllegalReq;
        default: r.outcome = (r.code_known && r.code != 8'd0) ? OutOtherCode : OutQuiet;
      endcase
    end else if (sense_len == 8'd4) begin
      if (sense_mem[0][7]) begin
        r.known = 1'b1;
        r.block = {11'd0, sense_mem[1][4:0], sense_mem[2], sense_mem[3]};
      end
      r.key = sense_mem[0][6:0];
      case (r.key)
        LegSeek15, LegSeek02: r.outcome = OutSeek;
        LegBad01, LegBad03, LegBad11, LegBad12, LegBad14, LegBad19: begin
          r.outcome = r.known ? OutBadKnown : OutBadUnknown;
          bump = 1'b1;
        end
        LegRecovered: begin
          r.outcome = r.known ? OutRecKnown : OutRecUnknown;
          bump = 1'b1;
        end
        LegIllCmd:   r.outcome = OutIllegalCmd;
        LegIllAddr:  r.outcome = OutIllegalAddr;
        LegBadArg:   r.outcome = OutBadArg;
        LegCartChg:  r.outcome = OutCartChanged;
        LegBadLun:   r.outcome = OutInvalidLun;
        LegUnformat: r.outcome = OutUnformatted;
        LegNone:     r.outcome = OutNoError;
        default:     r.outcome = OutUnknownLeg;
      endcase
    end else begin
      r.outcome = OutBadSense;
      r.stop = 1'b1;
    end
    if (!r.known) begin
      r.block = '0;
    end
    r.resume = r.known ? r.block + 32'd1 : 32'd0;
    if (bump && bad_total != 32'hFFFF_FFFF) begin
      bad_total++;
    end
    r.total = bad_total;
    return r;
  endfunction

  function automatic bit predict_request(input logic req, input logic [7:0] st,
                                         input logic [7:0] len, input logic [7:0] octet,
                                         output sense_result_t res);
    res = '0;
    if (!req) begin
      gathering = 1'b0;
      seen_cnt = '0;
      sense_len = len;
      if (st == 8'd0) begin
        res.total = bad_total;
        return 1'b1;
      end
      if (len == 8'd0) begin
        res = decode_sense();
        return 1'b1;
      end
      gathering = 1'b1;
      return 1'b0;
    end
    if (!gathering) begin
      return 1'b0;
    end
    if (seen_cnt < StoreDepth) begin
      sense_mem[seen_cnt[StoreIdxW-1:0]] = octet;
    end
    seen_cnt++;
    if (seen_cnt == sense_len) begin
      gathering = 1'b0;
      res = decode_sense();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic req, input logic [7:0] st, input logic [7:0] len,
                              input logic [7:0] octet);
    int gap;
    bit ignored;
    bit has_result;
    sense_result_t res;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      req_type_i = 1'($urandom);
      status_byte_i = 8'($urandom);
      sense_length_i = 8'($urandom);
      sense_byte_i = 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_type_i = req;
    status_byte_i = st;
    sense_length_i = len;
    sense_byte_i = octet;
    in_valid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    ignored = req && !gathering;
    has_result = predict_request(req, st, len, octet, res);
    if (has_result) begin
      pending_results.push_back(res);
    end
    if (!ignored) begin
      useful_items++;
    end
  endtask

  task automatic send_status(input logic [7:0] st, input logic [7:0] len);
    send_request(1'b0, st, len, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] octet);
    send_request(1'b1, 8'($urandom), 8'($urandom), octet);
  endtask

  task automatic send_sense(input logic [7:0] st, input octet_q_t q);
    send_status(st, 8'(q.size()));
    foreach (q[i]) begin
      send_byte(q[i]);
    end
  endtask

  function automatic octet_q_t fixed_sense(input int len, input logic [7:0] b0,
                                           input logic [7:0] b2, input logic [31:0] blk,
                                           input logic [7:0] code);
    octet_q_t q;
    for (int i = 0; i < len; i++) begin
      q.push_back(8'($urandom));
    end
    q[0] = b0;
    if (len > 2) begin
      q[2] = b2;
    end
    if (len > 6) begin
      q[3] = blk[31:24];
      q[4] = blk[23:16];
      q[5] = blk[15:8];
      q[6] = blk[7:0];
    end
    if (len > 12) begin
      q[12] = code;
    end
    return q;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      report_failure($sformatf("%s mismatch: expected %0h, got %0h", name, exp_val, act_val));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_failure("result with no pending request");
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", 32'(want.outcome), 32'(outcome_o));
        check_field("stop_request", 32'(want.stop), 32'(stop_request_o));
        check_field("is_extended", 32'(want.ext), 32'(is_extended_o));
        check_field("block_known", 32'(want.known), 32'(block_known_o));
        check_field("block_address", want.block, block_address_o);
        check_field("resume_block", want.resume, resume_block_o);
        check_field("sense_key", 32'(want.key), 32'(sense_key_o));
        check_field("code_known", 32'(want.code_known), 32'(code_known_o));
        check_field("additional_code", 32'(want.code), 32'(additional_code_o));
        check_field("bad_block_total", want.total, bad_block_total_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap(out_stall_pct);
      out_ready_i = (stall_left == 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  task automatic test_immediate_status();
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_status(8'h00, 8'h00);
    send_status(8'h00, 8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_status(8'hFF, 8'h00);
    send_status(8'h80, 8'h00);
    send_status(8'h01, 8'h00);
  endtask

  task automatic test_extended_sense();
    send_sense(8'h02, fixed_sense(18, 8'hF0, {4'hF, KeyMedium}, 32'h1234_5678, 8'h11));
    send_sense(8'h02, fixed_sense(7, 8'hF1, {4'h0, KeyMedium}, 32'hFFFF_FFFF, 8'h00));
    send_sense(8'h02, fixed_sense(3, 8'h70, {4'hA, KeyRecovered}, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(8, 8'hF0, {4'h0, KeyRecovered}, 32'h0, 8'h00));
    send_sense(8'hFF, fixed_sense(13, 8'hF0, {4'h5, KeyRecovered}, 32'hFFFF_FFFE, 8'hFF));
    send_sense(8'h02, fixed_sense(13, 8'h71, {4'h0, KeyHardware}, 32'h0, 8'h44));
    send_sense(8'h02, fixed_sense(14, 8'hF1, {4'h0, KeyIllegal}, 32'h8000_0001, 8'h20));
    send_sense(8'h02, fixed_sense(13, 8'h70, 8'h06, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(13, 8'h70, 8'hF6, 32'h0, 8'h2A));
    send_sense(8'h02, fixed_sense(12, 8'hF0, 8'h0F, 32'h1, 8'h2A));
    send_sense(8'h02, fixed_sense(6, 8'hF0, {4'h0, KeyMedium}, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(4, 8'hF1, {4'h0, KeyMedium}, 32'h0, 8'h00));
  endtask

  task automatic test_legacy_sense();
    for (int i = 0; i <= 16; i++) begin
      send_sense(8'h02, fixed_sense(4, {1'(i % 2), legacy_code(i)}, 8'($urandom), 32'h0,
                                    8'h00));
    end
    send_sense(8'h02, fixed_sense(4, {1'b1, LegRecovered}, 8'hFF, 32'h0, 8'h00));
  endtask

  task automatic test_malformed_sense();
    send_sense(8'h02, fixed_sense(1, 8'h70, 8'h00, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(2, 8'hF0, 8'h00, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(3, 8'h72, {4'h0, KeyMedium}, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(5, {1'b1, LegBad01}, 8'h00, 32'h0, 8'h00));
    send_status(8'h02, 8'd10);
    repeat (3) send_byte(8'($urandom));
    send_sense(8'h02, fixed_sense(4, {1'b1, LegBad11}, 8'h12, 32'h0, 8'h00));
    send_sense(8'h02, fixed_sense(255, 8'hF0, {4'h0, KeyMedium}, 32'hCAFE_0000, 8'h5A));
  endtask

  task automatic test_random_traffic(input int target, input int in_pct, input int out_pct);
    int start;
    int pick;
    int len;
    int cut;
    int sel;
    logic [7:0] b0;
    logic [31:0] blk;
    logic [7:0] code;
    start = useful_items;
    in_gap_pct = in_pct;
    out_stall_pct = out_pct;
    while (useful_items - start < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          len = 4;
        end else if (sel < 85) begin
          len = $urandom_range(20, 1);
        end else if (sel < 97) begin
          len = $urandom_range(60, 21);
        end else begin
          len = $urandom_range(255, 61);
        end
        sel = $urandom_range(9);
        if (sel < 4) begin
          b0 = {1'($urandom), 6'b111000, 1'($urandom)};
        end else if (sel < 7) begin
          b0 = {1'($urandom), legacy_code($urandom_range(16))};
        end else begin
          b0 = 8'($urandom);
        end
        sel = $urandom_range(9);
        blk = (sel < 2) ? 32'hFFFF_FFFF : (sel == 2) ? 32'hFFFF_FFFE : $urandom;
        code = $urandom_range(1) ? 8'h00 : 8'($urandom);
        send_sense(8'($urandom_range(255, 1)), fixed_sense(len, b0, 8'($urandom), blk, code));
      end else if (pick < 80) begin
        send_status(8'h00, 8'($urandom));
      end else if (pick < 87) begin
        send_status(8'($urandom_range(255, 1)), 8'h00);
      end else if (pick < 95) begin
        len = $urandom_range(20, 2);
        cut = $urandom_range(len - 1, 1);
        send_status(8'($urandom_range(255, 1)), 8'(len));
        repeat (cut) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    status_byte_i = '0;
    sense_length_i = '0;
    sense_byte_i = '0;
    out_ready_i = 1'b0;
    stall_left = 0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    fail_count = 0;
    useful_items = 0;
    cycle_count = 0;
    sense_len = '0;
    seen_cnt = '0;
    gathering = 1'b0;
    bad_total = '0;
    foreach (sense_mem[i]) begin
      sense_mem[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_immediate_status();
    test_extended_sense();
    test_legacy_sense();
    test_malformed_sense();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 30, 30);
    test_random_traffic(500, 70, 60);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scsc_pkg.sv
rtl/scsi_sense_classifier.sv
sim/tb_top.sv
